[rtl/kss_pkg.sv]
// kss_pkg: shared types, constants and the crc step of the key socket scanner
// used by key_socket_scanner and its bench; no dependencies
`timescale 1ns / 1ps

package kss_pkg;

  localparam int NumSockets  = 8;
  localparam int SockW       = 3;
  localparam int RecordBytes = 32;

  // result queue depth, pointers and count in the top level are two bits wide
  localparam int OutDepth = 3;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // configuration register indexes
  localparam logic CfgSettle  = 1'b0;
  localparam logic CfgConfirm = 1'b1;

  localparam logic [7:0] SettleReset  = 8'd2;
  localparam logic [1:0] ConfirmReset = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SELECT,
    PH_DETECT,
    PH_ENABLE,
    PH_XFER,
    PH_OK,
    PH_ERR,
    PH_DISABLE
  } phase_e;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_VALID,
    ST_READ_ERR,
    ST_CRC_ERR
  } status_e;

  typedef enum logic [1:0] {
    PWR_OFF,
    PWR_SENSE,
    PWR_ON
  } pwr_e;

  // per socket debounce entry, all zero means empty
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] pending;
    logic [1:0] left;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // control handed from the sequencer stage to the debounce stage
  typedef struct packed {
    logic [SockW-1:0] socket;
    logic             select_update;
    logic [1:0]       power_mode;
    logic             start_read;
    logic             start_write;
    logic             abort_xfer;
    logic             program_done;
    logic [1:0]       program_status;
    logic             dbv;
    logic [1:0]       dbs;
  } seq_t;

  typedef struct packed {
    logic [SockW-1:0] socket_select;
    logic             select_update;
    logic [1:0]       power_mode;
    logic             start_read;
    logic             start_write;
    logic             abort_xfer;
    logic             commit_record;
    logic             program_done;
    logic [1:0]       program_status;
    logic             status_change;
    logic [1:0]       new_status;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/kss_ram.sv]
// kss_ram: generic single write port, single read port ram with registered read
// read returns the old data on a same-address write; no dependencies
`timescale 1ns / 1ps

module kss_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/key_socket_scanner.sv]
// key_socket_scanner: round-robin key socket scanner with crc check and debounce
// depends on kss_pkg and kss_ram
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid_i / in_ready_o) carries one poll per beat: the tick,
// the select, sense and transfer status and an optional program request.
// Output channel (out_valid_o / out_ready_i) returns exactly one result beat
// per poll, in order: socket select, control pulses, power mode, program
// status and debounced socket status.
// A poll can be taken every cycle while in_ready_o is high: the sequencer
// runs in the accept cycle and reads the socket's debounce entry from the
// ram, the next cycle modifies and writes it back (a same-socket access in
// flight is forwarded), then the result enters a three-deep output queue.
// When the receiver stalls the queue fills and in_ready_o drops once queue
// plus in-flight poll reach three; no beat is lost.
// Reset brings the sequencer to idle on socket 0, settle_ticks to 2 and
// confirm_count to 2; all sockets read as empty at once through per-socket
// valid bits, so no clearing pass is needed.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle.

module key_socket_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       ms_tick_i,
  input  logic       shift_done_i,
  input  logic       tip_high_i,
  input  logic       byte_valid_i,
  input  logic [7:0] record_byte_i,
  input  logic       xfer_done_i,
  input  logic       xfer_ok_i,
  input  logic       program_request_i,
  input  logic [2:0] program_slot_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] socket_select_o,
  output logic       select_update_o,
  output logic [1:0] power_mode_o,
  output logic       start_read_o,
  output logic       start_write_o,
  output logic       abort_xfer_o,
  output logic       commit_record_o,
  output logic       program_done_o,
  output logic [1:0] program_status_o,
  output logic       status_change_o,
  output logic [1:0] new_status_o
);

  // configuration
  logic [7:0] settle_q;
  logic [1:0] confirm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= kss_pkg::SettleReset;
      confirm_q <= kss_pkg::ConfirmReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kss_pkg::CfgSettle:  settle_q  <= cfg_data_i;
        kss_pkg::CfgConfirm: confirm_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  kss_pkg::phase_e            phase_q, phase_d;
  logic [kss_pkg::SockW-1:0]  sock_q, sock_d;
  logic                       prog_q, prog_d;
  logic [7:0]                 elapsed_q, elapsed_d;
  logic [15:0]                crc_q, crc_d;
  logic [7:0]                 bidx_q, bidx_d;
  logic [15:0]                rcrc_q, rcrc_d;
  logic [1:0]                 pmode_q, pmode_d;
  kss_pkg::seq_t              seq;

  logic in_acc;
  logic p1_valid_q;
  logic [1:0] cnt_q;
  logic pop;

  assign in_ready_o = ((3'(cnt_q) + 3'(p1_valid_q)) <= 3'(kss_pkg::OutDepth - 1));
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] e_inc;
    logic       wait_more;
    logic       good;
    phase_d   = phase_q;
    sock_d    = sock_q;
    prog_d    = prog_q;
    crc_d     = crc_q;
    bidx_d    = bidx_q;
    rcrc_d    = rcrc_q;
    pmode_d   = pmode_q;
    seq       = '0;
    e_inc     = (ms_tick_i && elapsed_q != 8'hFF) ? elapsed_q + 8'd1 : elapsed_q;
    elapsed_d = e_inc;
    wait_more = e_inc < settle_q;
    good      = (bidx_q >= 8'(kss_pkg::RecordBytes)) && (crc_q == rcrc_q);

    // a program request restarts the sequence on the requested socket
    if (program_request_i &&
        (4'(program_slot_i) < 4'(kss_pkg::NumSockets))) begin
      seq.abort_xfer = 1'b1;
      pmode_d        = kss_pkg::PWR_OFF;
      phase_d        = kss_pkg::PH_IDLE;
      sock_d         = kss_pkg::SockW'(program_slot_i);
      prog_d         = 1'b1;
    end

    unique case (phase_d)
      kss_pkg::PH_IDLE: begin
        seq.select_update = 1'b1;
        phase_d           = kss_pkg::PH_SELECT;
      end
      kss_pkg::PH_SELECT: begin
        if (shift_done_i) begin
          pmode_d   = kss_pkg::PWR_SENSE;
          elapsed_d = '0;
          phase_d   = kss_pkg::PH_DETECT;
        end
      end
      kss_pkg::PH_DETECT: begin
        if (!wait_more) begin
          if (!tip_high_i) begin
            if (prog_q) begin
              seq.program_done   = 1'b1;
              seq.program_status = kss_pkg::ST_EMPTY;
            end else begin
              seq.dbv = 1'b1;
              seq.dbs = kss_pkg::ST_EMPTY;
            end
            pmode_d   = kss_pkg::PWR_OFF;
            prog_d    = 1'b0;
            elapsed_d = '0;
            phase_d   = kss_pkg::PH_DISABLE;
          end else begin
            pmode_d   = kss_pkg::PWR_ON;
            elapsed_d = '0;
            phase_d   = kss_pkg::PH_ENABLE;
          end
        end
      end
      kss_pkg::PH_ENABLE: begin
        if (!wait_more) begin
          if (prog_d) begin
            seq.start_write = 1'b1;
          end else begin
            seq.start_read = 1'b1;
            crc_d          = kss_pkg::CrcInit;
            bidx_d         = '0;
            rcrc_d         = '0;
          end
          phase_d = kss_pkg::PH_XFER;
        end
      end
      kss_pkg::PH_XFER: begin
        if (byte_valid_i && !prog_q) begin
          if (bidx_q < 8'(kss_pkg::RecordBytes - 2)) begin
            crc_d = kss_pkg::crc16_byte(crc_q, record_byte_i);
          end else if (bidx_q == 8'(kss_pkg::RecordBytes - 2)) begin
            rcrc_d = {rcrc_q[15:8], record_byte_i};
          end else if (bidx_q == 8'(kss_pkg::RecordBytes - 1)) begin
            rcrc_d = {record_byte_i, rcrc_q[7:0]};
          end
          if (bidx_q != 8'hFF) begin
            bidx_d = bidx_q + 8'd1;
          end
        end
        if (xfer_done_i) begin
          phase_d = xfer_ok_i ? kss_pkg::PH_OK : kss_pkg::PH_ERR;
        end
      end
      kss_pkg::PH_ERR: begin
        if (prog_q) begin
          seq.program_done   = 1'b1;
          seq.program_status = kss_pkg::ST_READ_ERR;
        end else begin
          seq.dbv = 1'b1;
          seq.dbs = kss_pkg::ST_READ_ERR;
        end
        pmode_d   = kss_pkg::PWR_OFF;
        prog_d    = 1'b0;
        elapsed_d = '0;
        phase_d   = kss_pkg::PH_DISABLE;
      end
      kss_pkg::PH_OK: begin
        if (prog_q) begin
          seq.program_done   = 1'b1;
          seq.program_status = kss_pkg::ST_VALID;
        end else begin
          seq.dbv = 1'b1;
          seq.dbs = good ? kss_pkg::ST_VALID : kss_pkg::ST_CRC_ERR;
        end
        pmode_d   = kss_pkg::PWR_OFF;
        prog_d    = 1'b0;
        elapsed_d = '0;
        phase_d   = kss_pkg::PH_DISABLE;
      end
      kss_pkg::PH_DISABLE: begin
        if (!wait_more) begin
          sock_d  = (sock_q == kss_pkg::SockW'(kss_pkg::NumSockets - 1)) ?
                    '0 : sock_q + 1'b1;
          phase_d = kss_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase

    seq.socket     = sock_d;
    seq.power_mode = pmode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kss_pkg::PH_IDLE;
      sock_q    <= '0;
      prog_q    <= 1'b0;
      elapsed_q <= '0;
      crc_q     <= kss_pkg::CrcInit;
      bidx_q    <= '0;
      rcrc_q    <= '0;
      pmode_q   <= kss_pkg::PWR_OFF;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      sock_q    <= sock_d;
      prog_q    <= prog_d;
      elapsed_q <= elapsed_d;
      crc_q     <= crc_d;
      bidx_q    <= bidx_d;
      rcrc_q    <= rcrc_d;
      pmode_q   <= pmode_d;
    end
  end

  // debounce entries: ram plus per-socket valid bits, forwarding on back-to-back hits
  kss_pkg::seq_t             p1_q;
  logic [kss_pkg::EntryW-1:0] ram_rdata;
  logic                      ram_we;
  kss_pkg::entry_t           ent, ent_n;
  logic [kss_pkg::NumSockets-1:0] vld_q;
  logic                      rd_vld_q;
  logic                      fwd_hit_q;
  kss_pkg::entry_t           fwd_data_q;
  logic                      chg, commit;

  kss_ram #(
    .Width (kss_pkg::EntryW),
    .Depth (kss_pkg::NumSockets)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p1_q.socket),
    .wdata_i (ent_n),
    .re_i    (in_acc),
    .raddr_i (sock_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      p1_valid_q <= in_acc;
      if (ram_we) begin
        vld_q[p1_q.socket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_q       <= seq;
      rd_vld_q   <= vld_q[sock_d];
      fwd_hit_q  <= ram_we && (p1_q.socket == sock_d);
      fwd_data_q <= ent_n;
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      ent = fwd_data_q;
    end else if (rd_vld_q) begin
      ent = kss_pkg::entry_t'(ram_rdata);
    end else begin
      ent = '0;
    end
    ent_n  = ent;
    chg    = 1'b0;
    commit = 1'b0;
    if (p1_q.dbv && ent.status != p1_q.dbs) begin
      if (ent.pending != p1_q.dbs) begin
        ent_n.pending = p1_q.dbs;
        ent_n.left    = confirm_q;
      end else begin
        ent_n.left = ent.left - 2'd1;
        if (ent_n.left == 2'd0) begin
          ent_n.status = p1_q.dbs;
          chg          = 1'b1;
          commit       = (p1_q.dbs == kss_pkg::ST_VALID);
        end
      end
    end
  end

  assign ram_we = p1_valid_q && p1_q.dbv;

  // output queue
  kss_pkg::res_t fifo_q [kss_pkg::OutDepth];
  kss_pkg::res_t res_in;
  logic [1:0]    wptr_q, rptr_q;

  always_comb begin
    res_in.socket_select  = p1_q.socket;
    res_in.select_update  = p1_q.select_update;
    res_in.power_mode     = p1_q.power_mode;
    res_in.start_read     = p1_q.start_read;
    res_in.start_write    = p1_q.start_write;
    res_in.abort_xfer     = p1_q.abort_xfer;
    res_in.commit_record  = commit;
    res_in.program_done   = p1_q.program_done;
    res_in.program_status = p1_q.program_status;
    res_in.status_change  = chg;
    res_in.new_status     = ent_n.status;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (p1_valid_q) begin
        wptr_q <= (wptr_q == 2'(kss_pkg::OutDepth - 1)) ? 2'd0 : wptr_q + 2'd1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == 2'(kss_pkg::OutDepth - 1)) ? 2'd0 : rptr_q + 2'd1;
      end
      cnt_q <= cnt_q + 2'(p1_valid_q) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      fifo_q[wptr_q] <= res_in;
    end
  end

  kss_pkg::res_t head;
  assign head = fifo_q[rptr_q];

  assign socket_select_o  = head.socket_select;
  assign select_update_o  = head.select_update;
  assign power_mode_o     = head.power_mode;
  assign start_read_o     = head.start_read;
  assign start_write_o    = head.start_write;
  assign abort_xfer_o     = head.abort_xfer;
  assign commit_record_o  = head.commit_record;
  assign program_done_o   = head.program_done;
  assign program_status_o = head.program_status;
  assign status_change_o  = head.status_change;
  assign new_status_o     = head.new_status;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p1_valid_q && cnt_q == 2'(kss_pkg::OutDepth)))
    else $error("output queue overflow");

  a_prog_vs_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(program_done_o && status_change_o))
    else $error("program report and status change in one beat");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_record_o) |->
      (status_change_o && new_status_o == kss_pkg::ST_VALID))
    else $error("commit without change to valid");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(start_read_o && start_write_o))
    else $error("read and write started together");
`endif

endmodule

[verif/tb.sv]
// tb: self-checking bench for key_socket_scanner, a poll driver, a result monitor and
// a cycle-free scan predictor that tracks sockets, debounce and record crc on its own
// depends on kss_pkg and the key_socket_scanner rtl
`timescale 1ns / 1ps

module tb;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic       ms_tick;
    logic       shift_done;
    logic       tip_high;
    logic       byte_valid;
    logic [7:0] record_byte;
    logic       xfer_done;
    logic       xfer_ok;
    logic       program_request;
    logic [2:0] program_slot;
  } poll_t;

  // how the key in a socket answers a record read
  typedef enum int {
    REC_GOOD,
    REC_CORRUPT,
    REC_SHORT,
    REC_LONG,
    REC_FAIL
  } rec_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       ms_tick_i;
  logic       shift_done_i;
  logic       tip_high_i;
  logic       byte_valid_i;
  logic [7:0] record_byte_i;
  logic       xfer_done_i;
  logic       xfer_ok_i;
  logic       program_request_i;
  logic [2:0] program_slot_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] socket_select_o;
  logic       select_update_o;
  logic [1:0] power_mode_o;
  logic       start_read_o;
  logic       start_write_o;
  logic       abort_xfer_o;
  logic       commit_record_o;
  logic       program_done_o;
  logic [1:0] program_status_o;
  logic       status_change_o;
  logic [1:0] new_status_o;

  key_socket_scanner u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ms_tick_i        (ms_tick_i),
    .shift_done_i     (shift_done_i),
    .tip_high_i       (tip_high_i),
    .byte_valid_i     (byte_valid_i),
    .record_byte_i    (record_byte_i),
    .xfer_done_i      (xfer_done_i),
    .xfer_ok_i        (xfer_ok_i),
    .program_request_i(program_request_i),
    .program_slot_i   (program_slot_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .socket_select_o  (socket_select_o),
    .select_update_o  (select_update_o),
    .power_mode_o     (power_mode_o),
    .start_read_o     (start_read_o),
    .start_write_o    (start_write_o),
    .abort_xfer_o     (abort_xfer_o),
    .commit_record_o  (commit_record_o),
    .program_done_o   (program_done_o),
    .program_status_o (program_status_o),
    .status_change_o  (status_change_o),
    .new_status_o     (new_status_o)
  );

  // scanner shadow state
  logic [7:0]       settle_cfg;
  logic [1:0]       confirm_cfg;
  kss_pkg::phase_e  scan_ph;
  logic [2:0]       cur_sock;
  logic             prog_flag;
  logic [7:0]       elapsed;
  logic [15:0]      crc_acc;
  logic [7:0]       byte_idx;
  logic [15:0]      rec_crc;
  kss_pkg::pwr_e    power;
  kss_pkg::status_e sock_status [kss_pkg::NumSockets];
  kss_pkg::status_e pend_status [kss_pkg::NumSockets];
  logic [1:0]       confirm_left [kss_pkg::NumSockets];

  // poll generation state
  bit          plug_in [kss_pkg::NumSockets];
  rec_mode_e   sock_mode [kss_pkg::NumSockets];
  logic [7:0]  rec_bytes [48];
  int          rec_len;
  bit          rec_armed;
  int          tick_pm;
  int          send_idle_pct;
  int          recv_stall_pct;

  poll_t         poll_q [$];
  kss_pkg::res_t scan_res_q [$];
  poll_t         drv_item;
  poll_t         taken_item;
  kss_pkg::res_t next_res;
  kss_pkg::res_t want_res;
  int          gen_count;
  int          sent_count;
  int          taken_count;
  int          beats_checked;
  int          changes_seen;
  int          commits_seen;
  int          programs_seen;
  int          mismatches;
  int          idle_cycles;
  event        poll_taken;

  function automatic bit chance(input int per_mille);
    return $urandom_range(999) < per_mille;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] v;
    logic        fb;
    v = acc;
    for (int n = 0; n < 8; n++) begin
      fb = v[0] ^ data[n];
      v  = {1'b0, v[15:1]};
      if (fb) v = v ^ kss_pkg::CrcPoly;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic debounce_status(input kss_pkg::status_e s, inout kss_pkg::res_t r);
    if (sock_status[cur_sock] != s) begin
      if (pend_status[cur_sock] != s) begin
        pend_status[cur_sock]  = s;
        confirm_left[cur_sock] = confirm_cfg;
      end else begin
        // a zero load wraps, so it acts as four
        confirm_left[cur_sock] = confirm_left[cur_sock] - 2'd1;
        if (confirm_left[cur_sock] == 2'd0) begin
          sock_status[cur_sock] = s;
          r.status_change       = 1'b1;
          r.commit_record       = (s == kss_pkg::ST_VALID);
        end
      end
    end
  endtask

  task automatic post_status(input kss_pkg::status_e s, inout kss_pkg::res_t r);
    if (prog_flag) begin
      r.program_done   = 1'b1;
      r.program_status = s;
    end else begin
      debounce_status(s, r);
    end
  endtask

  task automatic power_down;
    power     = kss_pkg::PWR_OFF;
    prog_flag = 1'b0;
    elapsed   = '0;
    scan_ph   = kss_pkg::PH_DISABLE;
  endtask

  task automatic scan_step(input poll_t p, output kss_pkg::res_t r);
    r = '0;
    if (p.ms_tick && elapsed != 8'hFF) elapsed = elapsed + 8'd1;
    if (p.program_request && int'(p.program_slot) < kss_pkg::NumSockets) begin
      r.abort_xfer = 1'b1;
      power        = kss_pkg::PWR_OFF;
      scan_ph      = kss_pkg::PH_IDLE;
      cur_sock     = p.program_slot;
      prog_flag    = 1'b1;
    end
    case (scan_ph)
      kss_pkg::PH_IDLE: begin
        r.select_update = 1'b1;
        scan_ph         = kss_pkg::PH_SELECT;
      end
      kss_pkg::PH_SELECT: begin
        if (p.shift_done) begin
          power   = kss_pkg::PWR_SENSE;
          elapsed = '0;
          scan_ph = kss_pkg::PH_DETECT;
        end
      end
      kss_pkg::PH_DETECT: begin
        if (elapsed >= settle_cfg) begin
          if (!p.tip_high) begin
            post_status(kss_pkg::ST_EMPTY, r);
            power_down();
          end else begin
            power   = kss_pkg::PWR_ON;
            elapsed = '0;
            scan_ph = kss_pkg::PH_ENABLE;
          end
        end
      end
      kss_pkg::PH_ENABLE: begin
        if (elapsed >= settle_cfg) begin
          if (prog_flag) begin
            r.start_write = 1'b1;
          end else begin
            r.start_read = 1'b1;
            crc_acc      = kss_pkg::CrcInit;
            byte_idx     = '0;
            rec_crc      = '0;
          end
          scan_ph = kss_pkg::PH_XFER;
        end
      end
      kss_pkg::PH_XFER: begin
        if (p.byte_valid && !prog_flag) begin
          // body feeds the crc, the last two bytes hold it little-endian
          if (byte_idx < kss_pkg::RecordBytes - 2)
            crc_acc = crc_step(crc_acc, p.record_byte);
          else if (byte_idx == kss_pkg::RecordBytes - 2) rec_crc[7:0] = p.record_byte;
          else if (byte_idx == kss_pkg::RecordBytes - 1) rec_crc[15:8] = p.record_byte;
          if (byte_idx != 8'hFF) byte_idx = byte_idx + 8'd1;
        end
        if (p.xfer_done) scan_ph = p.xfer_ok ? kss_pkg::PH_OK : kss_pkg::PH_ERR;
      end
      kss_pkg::PH_ERR: begin
        post_status(kss_pkg::ST_READ_ERR, r);
        power_down();
      end
      kss_pkg::PH_OK: begin
        if (prog_flag) post_status(kss_pkg::ST_VALID, r);
        else debounce_status((byte_idx >= kss_pkg::RecordBytes && crc_acc == rec_crc) ?
                             kss_pkg::ST_VALID : kss_pkg::ST_CRC_ERR, r);
        power_down();
      end
      kss_pkg::PH_DISABLE: begin
        if (elapsed >= settle_cfg) begin
          cur_sock = (int'(cur_sock) == kss_pkg::NumSockets - 1) ? '0 : cur_sock + 3'd1;
          scan_ph  = kss_pkg::PH_IDLE;
        end
      end
    endcase
    r.socket_select = cur_sock;
    r.power_mode    = power;
    r.new_status    = sock_status[cur_sock];
  endtask

  // builds the next poll from where the scanner stands after every earlier poll
  task automatic make_poll(output poll_t p);
    logic [15:0] c;
    int          fill;
    int          at;
    int          m;
    p.ms_tick         = chance(tick_pm);
    p.shift_done      = chance(scan_ph == kss_pkg::PH_SELECT ? 750 : 500);
    p.tip_high        = 1'($urandom_range(1));
    p.byte_valid      = chance(200);
    p.record_byte     = 8'($urandom_range(255));
    p.xfer_done       = chance(100);
    p.xfer_ok         = 1'($urandom_range(1));
    p.program_request = chance(scan_ph == kss_pkg::PH_XFER ? 3 : 12);
    p.program_slot    = 3'($urandom_range(7));
    if (scan_ph != kss_pkg::PH_XFER) rec_armed = 1'b0;
    if (chance(80)) begin
      // noise beat
      p.ms_tick         = 1'($urandom_range(1));
      p.shift_done      = 1'($urandom_range(1));
      p.byte_valid      = 1'($urandom_range(1));
      p.xfer_done       = 1'($urandom_range(1));
      p.program_request = chance(200);
    end else begin
      case (scan_ph)
        kss_pkg::PH_IDLE: if (chance(100)) plug_in[cur_sock] = !plug_in[cur_sock];
        kss_pkg::PH_DETECT:
          p.tip_high = chance(920) ? plug_in[cur_sock] : !plug_in[cur_sock];
        kss_pkg::PH_XFER: begin
          if (prog_flag) begin
            p.xfer_done = chance(300);
            p.xfer_ok   = chance(750);
          end else begin
            if (!rec_armed) begin
              if (chance(150)) begin
                m                  = $urandom_range(7);
                sock_mode[cur_sock] = (m < 4) ? REC_GOOD : rec_mode_e'(m - 3);
              end
              fill = $urandom_range(9);
              c    = kss_pkg::CrcInit;
              for (int n = 0; n < kss_pkg::RecordBytes - 2; n++) begin
                rec_bytes[n] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF :
                               8'($urandom_range(255));
                c = crc_step(c, rec_bytes[n]);
              end
              rec_bytes[kss_pkg::RecordBytes-2] = c[7:0];
              rec_bytes[kss_pkg::RecordBytes-1] = c[15:8];
              for (int n = kss_pkg::RecordBytes; n < 48; n++)
                rec_bytes[n] = 8'($urandom_range(255));
              rec_len = kss_pkg::RecordBytes;
              case (sock_mode[cur_sock])
                REC_CORRUPT: begin
                  at            = $urandom_range(kss_pkg::RecordBytes - 1);
                  rec_bytes[at] = rec_bytes[at] ^ (8'h01 << $urandom_range(7));
                end
                REC_SHORT: rec_len = $urandom_range(kss_pkg::RecordBytes - 1);
                REC_LONG:  rec_len = kss_pkg::RecordBytes + int'($urandom_range(8, 1));
                REC_FAIL:  rec_len = $urandom_range(kss_pkg::RecordBytes);
                default: ;
              endcase
              rec_armed = 1'b1;
            end
            if (int'(byte_idx) < rec_len) begin
              p.byte_valid = chance(850);
              p.xfer_done  = 1'b0;
              if (p.byte_valid) p.record_byte = rec_bytes[byte_idx];
            end else begin
              p.byte_valid = chance(100);
              p.xfer_done  = chance(800);
              p.xfer_ok    = (sock_mode[cur_sock] != REC_FAIL);
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic queue_poll(input logic tk, input logic sd, input logic tp, input logic bv,
                            input logic [7:0] rb, input logic xd, input logic xo,
                            input logic pr, input logic [2:0] ps);
    poll_q.push_back({tk, sd, tp, bv, rb, xd, xo, pr, ps});
    gen_count++;
  endtask

  // drains the block, writes both registers, then feeds polls one decision at a time
  task automatic run_phase(input logic [7:0] settle_v, input logic [1:0] confirm_v,
                           input int send_pct, input int stall_pct, input int tick_v,
                           input int n_polls);
    poll_t p;
    while (scan_res_q.size() != 0 || taken_count != gen_count) @(posedge clk_i);
    settle_cfg  = settle_v;
    confirm_cfg = confirm_v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= kss_pkg::CfgSettle;
    cfg_data_i <= settle_v;
    @(negedge clk_i);
    cfg_idx_i  <= kss_pkg::CfgConfirm;
    cfg_data_i <= {6'b0, confirm_v};
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    tick_pm        = tick_v;
    for (int k = 0; k < n_polls; k++) begin
      while (taken_count != gen_count) @(poll_taken);
      make_poll(p);
      poll_q.push_back(p);
      gen_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // poll driver
  always @(negedge clk_i) begin
    if (rst_ni && taken_count == sent_count) begin
      if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item          = poll_q.pop_front();
        ms_tick_i         <= drv_item.ms_tick;
        shift_done_i      <= drv_item.shift_done;
        tip_high_i        <= drv_item.tip_high;
        byte_valid_i      <= drv_item.byte_valid;
        record_byte_i     <= drv_item.record_byte;
        xfer_done_i       <= drv_item.xfer_done;
        xfer_ok_i         <= drv_item.xfer_ok;
        program_request_i <= drv_item.program_request;
        program_slot_i    <= drv_item.program_slot;
        in_valid_i        <= 1'b1;
        sent_count++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // every accepted poll moves the shadow scanner one step
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      taken_item = {ms_tick_i, shift_done_i, tip_high_i, byte_valid_i, record_byte_i,
                    xfer_done_i, xfer_ok_i, program_request_i, program_slot_i};
      scan_step(taken_item, next_res);
      scan_res_q.push_back(next_res);
      taken_count++;
      -> poll_taken;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scan_res_q.size() == 0) begin
        report_mismatch("result beat with no poll pending", 1, 0);
      end else begin
        want_res = scan_res_q.pop_front();
        beats_checked++;
        if (socket_select_o !== want_res.socket_select)
          report_mismatch("socket_select", int'(socket_select_o),
                          int'(want_res.socket_select));
        if (select_update_o !== want_res.select_update)
          report_mismatch("select_update", int'(select_update_o),
                          int'(want_res.select_update));
        if (power_mode_o !== want_res.power_mode)
          report_mismatch("power_mode", int'(power_mode_o), int'(want_res.power_mode));
        if (start_read_o !== want_res.start_read)
          report_mismatch("start_read", int'(start_read_o), int'(want_res.start_read));
        if (start_write_o !== want_res.start_write)
          report_mismatch("start_write", int'(start_write_o), int'(want_res.start_write));
        if (abort_xfer_o !== want_res.abort_xfer)
          report_mismatch("abort_xfer", int'(abort_xfer_o), int'(want_res.abort_xfer));
        if (commit_record_o !== want_res.commit_record)
          report_mismatch("commit_record", int'(commit_record_o),
                          int'(want_res.commit_record));
        if (program_done_o !== want_res.program_done)
          report_mismatch("program_done", int'(program_done_o),
                          int'(want_res.program_done));
        if (program_status_o !== want_res.program_status)
          report_mismatch("program_status", int'(program_status_o),
                          int'(want_res.program_status));
        if (status_change_o !== want_res.status_change)
          report_mismatch("status_change", int'(status_change_o),
                          int'(want_res.status_change));
        if (new_status_o !== want_res.new_status)
          report_mismatch("new_status", int'(new_status_o), int'(want_res.new_status));
        changes_seen  += int'(want_res.status_change);
        commits_seen  += int'(want_res.commit_record);
        programs_seen += int'(want_res.program_done);
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] no beat for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, scan_res_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = kss_pkg::CfgSettle;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    ms_tick_i         = 1'b0;
    shift_done_i      = 1'b0;
    tip_high_i        = 1'b0;
    byte_valid_i      = 1'b0;
    record_byte_i     = '0;
    xfer_done_i       = 1'b0;
    xfer_ok_i         = 1'b0;
    program_request_i = 1'b0;
    program_slot_i    = '0;
    out_ready_i       = 1'b0;
    settle_cfg        = kss_pkg::SettleReset;
    confirm_cfg       = kss_pkg::ConfirmReset;
    scan_ph           = kss_pkg::PH_IDLE;
    cur_sock          = '0;
    prog_flag         = 1'b0;
    elapsed           = '0;
    crc_acc           = kss_pkg::CrcInit;
    byte_idx          = '0;
    rec_crc           = '0;
    power             = kss_pkg::PWR_OFF;
    for (int s = 0; s < kss_pkg::NumSockets; s++) begin
      sock_status[s]  = kss_pkg::ST_EMPTY;
      pend_status[s]  = kss_pkg::ST_EMPTY;
      confirm_left[s] = '0;
      plug_in[s]      = 1'($urandom_range(1));
      sock_mode[s]    = rec_mode_e'($urandom_range(4));
    end
    rec_len        = kss_pkg::RecordBytes;
    rec_armed      = 1'b0;
    tick_pm        = 800;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_count      = 0;
    sent_count     = 0;
    taken_count    = 0;
    beats_checked  = 0;
    changes_seen   = 0;
    commits_seen   = 0;
    programs_seen  = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk under reset settings: short read, requests, empty socket, write error
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 1, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 1, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 1, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 1, 8'hFF, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 1, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 1, 1, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    // request beat carries transfer inputs that must be dropped
    queue_poll(1, 1, 1, 1, 8'hFF, 1, 1, 1, 3'd7);
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 1, 3'd0);
    queue_poll(0, 1, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 1, 3'd5);
    queue_poll(0, 1, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 1, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 1, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(1, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 1, 0, 0, 3'd0);
    queue_poll(0, 0, 0, 0, 8'h00, 0, 0, 0, 3'd0);

    run_phase(8'd1,   2'd1, 0,  0,  800, 300);
    run_phase(8'd3,   2'd3, 67, 0,  800, 300);
    run_phase(8'd2,   2'd2, 0,  67, 800, 300);
    run_phase(8'd1,   2'd3, 26, 26, 800, 300);
    run_phase(8'd255, 2'd1, 0,  0,  970, 400);

    while (scan_res_q.size() != 0 || taken_count != gen_count) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("polls %0d, result beats %0d, status changes %0d, commits %0d",
             taken_count, beats_checked, changes_seen, commits_seen);
    $display("program reports %0d; settle 1 to 255 and confirm 1 to 3 under idle, stall %s",
             programs_seen, "and mixed backpressure");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
